### hw/rtl/ptok_pkg.sv
// Shared constants, types and helpers of the property line tokenizer.
package ptok_pkg;

	localparam int PEND_DEPTH_DEF = 16;

	localparam logic [2:0] MODE_LINE    = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_KEY     = 3'd2;
	localparam logic [2:0] MODE_VALUE   = 3'd3;
	localparam logic [2:0] MODE_ESC     = 3'd4;
	localparam logic [2:0] MODE_ESC_CR  = 3'd5;

	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_COL  = 8'h3A;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] CH_N    = 8'h6E;
	localparam logic [7:0] CH_F    = 8'h66;

	typedef struct packed {
		logic accept;
		logic rd;
		logic ld_flush;
		logic ld_char;
		logic ld_end;
	} cmd_t;

	typedef struct packed {
		logic has_flush;
		logic has_char;
		logic has_end;
		logic slot_free;
		logic flush_last;
	} status_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

### hw/rtl/property_line_tokenizer.sv
// Top level of the property line tokenizer.
//
//  channel  dir  handshake           payload
//  input    in   in_valid/in_ready   func, byte_req
//  output   out  out_valid/out_ready kind, ch, overflow, last
//
// A request with no result ends on acceptance; one with a single result then
// passes the CHR or END state. Each held whitespace byte flushed ahead of a
// key/value byte adds a registered buffer read (FL_RD), then an output load (FL_OUT).
// arst_n clears parse state, fill count and output valid; the buffer needs no clearing.
// A stalled output holds the sequencer; in_ready is high only between requests.
module property_line_tokenizer #(
	parameter int PEND_DEPTH = ptok_pkg::PEND_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [7:0] byte_req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] ch,
	output logic       overflow,
	output logic       last
);

	ptok_pkg::cmd_t    cmd;
	ptok_pkg::status_t stat;

	ptok_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptok_dp #(
		.PEND_DEPTH (PEND_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.byte_req  (byte_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.ch        (ch),
		.overflow  (overflow),
		.last      (last),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### hw/rtl/ptok_ctrl.sv
// Sequencer of the property line tokenizer: accept, flush held bytes, emit.
module ptok_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ptok_pkg::status_t stat,
	output ptok_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FL_RD  = 3'd1;
	localparam logic [2:0] ST_FL_OUT = 3'd2;
	localparam logic [2:0] ST_CHR    = 3'd3;
	localparam logic [2:0] ST_END    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	assign in_ready     = (state_q == ST_IDLE);
	assign cmd.accept   = in_valid && (state_q == ST_IDLE);
	assign cmd.rd       = (state_q == ST_FL_RD);
	assign cmd.ld_flush = (state_q == ST_FL_OUT) && stat.slot_free;
	assign cmd.ld_char  = (state_q == ST_CHR) && stat.slot_free;
	assign cmd.ld_end   = (state_q == ST_END) && stat.slot_free;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.has_flush)
						state_n = ST_FL_RD;
					else if (stat.has_char)
						state_n = ST_CHR;
					else if (stat.has_end)
						state_n = ST_END;
				end
			end
			ST_FL_RD: state_n = ST_FL_OUT;
			ST_FL_OUT: begin
				if (stat.slot_free)
					state_n = stat.flush_last ? ST_CHR : ST_FL_RD;
			end
			ST_CHR, ST_END: begin
				if (stat.slot_free)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

endmodule

### hw/rtl/ptok_dp.sv
// Datapath of the property line tokenizer: parse state, whitespace buffer, output register.
module ptok_dp #(
	parameter int PEND_DEPTH = ptok_pkg::PEND_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              func,
	input  logic [7:0]        byte_req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [7:0]        ch,
	output logic              overflow,
	output logic              last,
	input  ptok_pkg::cmd_t    cmd,
	output ptok_pkg::status_t stat
);

	localparam int CW = $clog2(PEND_DEPTH + 1);
	localparam int AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

	// parse state
	logic [2:0]    mode_q;
	logic          vs_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          rdrop_q;

	// held whitespace
	logic [7:0]    mem_q [PEND_DEPTH];
	logic [7:0]    rd_data_q;

	// latched plan of the current request
	logic [CW-1:0] idx_q;
	logic [CW-1:0] fl_n_q;
	logic [7:0]    chr_q;
	logic [1:0]    chr_kind_q;
	logic          end_ovf_q;

	// output register
	logic          ov_q;
	logic [1:0]    kind_q;
	logic [7:0]    ch_q;
	logic          ovfo_q;
	logic          last_q;

	logic          is_nl;
	logic          is_sep;
	logic [2:0]    nmode;
	logic          act_ch;
	logic [1:0]    ckind;
	logic [7:0]    cval;
	logic          act_end;
	logic          act_sv;
	logic          act_clr;

	logic [CW-1:0] cnt_e;
	logic          rd_e;
	logic          ovf_e;
	logic          vs_e;
	logic          c_ws;
	logic          hold;
	logic          hold_wr;
	logic          emit;
	logic [CW-1:0] cnt_n;
	logic          rd_n;
	logic          ovf_n;
	logic          vs_n;

	assign is_nl  = byte_req inside {ptok_pkg::CH_LF, ptok_pkg::CH_CR};
	assign is_sep = byte_req inside {ptok_pkg::CH_EQ, ptok_pkg::CH_COL};

	always_comb begin
		nmode   = mode_q;
		act_ch  = 1'b0;
		ckind   = ptok_pkg::KIND_KEY;
		cval    = byte_req;
		act_end = 1'b0;
		act_sv  = 1'b0;
		act_clr = 1'b0;
		if (func) begin
			if (mode_q >= ptok_pkg::MODE_KEY && mode_q <= ptok_pkg::MODE_ESC_CR)
				act_end = 1'b1;
			nmode = ptok_pkg::MODE_LINE;
		end else begin
			case (mode_q)
				ptok_pkg::MODE_COMMENT: begin
					if (is_nl)
						nmode = ptok_pkg::MODE_LINE;
				end
				ptok_pkg::MODE_KEY: begin
					if (is_sep)
						act_sv = 1'b1;
					else if (is_nl)
						act_end = 1'b1;
					else
						act_ch = 1'b1;
				end
				ptok_pkg::MODE_VALUE, ptok_pkg::MODE_ESC_CR: begin
					nmode = ptok_pkg::MODE_VALUE;
					// LF right after an escaped CR is part of the continuation
					if (!(mode_q == ptok_pkg::MODE_ESC_CR && byte_req == ptok_pkg::CH_LF)) begin
						if (byte_req == ptok_pkg::CH_BSL)
							nmode = ptok_pkg::MODE_ESC;
						else if (is_nl || byte_req == ptok_pkg::CH_NUL)
							act_end = 1'b1;
						else begin
							act_ch = 1'b1;
							ckind  = ptok_pkg::KIND_VALUE;
						end
					end
				end
				ptok_pkg::MODE_ESC: begin
					nmode = ptok_pkg::MODE_VALUE;
					ckind = ptok_pkg::KIND_VALUE;
					case (byte_req)
						ptok_pkg::CH_T: begin act_ch = 1'b1; cval = ptok_pkg::CH_TAB; end
						ptok_pkg::CH_R: begin act_ch = 1'b1; cval = ptok_pkg::CH_CR; end
						ptok_pkg::CH_N: begin act_ch = 1'b1; cval = ptok_pkg::CH_LF; end
						ptok_pkg::CH_F: begin act_ch = 1'b1; cval = ptok_pkg::CH_FF; end
						ptok_pkg::CH_CR: nmode = ptok_pkg::MODE_ESC_CR;
						ptok_pkg::CH_LF: nmode = ptok_pkg::MODE_VALUE;
						ptok_pkg::CH_NUL: act_end = 1'b1;
						default: act_ch = 1'b1;
					endcase
				end
				default: begin
					nmode = ptok_pkg::MODE_LINE;
					if (!ptok_pkg::is_ws(byte_req)) begin
						if (byte_req inside {ptok_pkg::CH_HASH, ptok_pkg::CH_BANG})
							nmode = ptok_pkg::MODE_COMMENT;
						else if (is_sep) begin
							act_clr = 1'b1;
							act_sv  = 1'b1;
						end else begin
							act_clr = 1'b1;
							act_ch  = 1'b1;
							nmode   = ptok_pkg::MODE_KEY;
						end
					end
				end
			endcase
		end
		if (act_end)
			nmode = ptok_pkg::MODE_LINE;
		if (act_sv)
			nmode = ptok_pkg::MODE_VALUE;
	end

	always_comb begin
		cnt_e   = act_clr ? '0 : cnt_q;
		rd_e    = act_clr ? 1'b0 : rdrop_q;
		ovf_e   = act_clr ? 1'b0 : ovf_q;
		vs_e    = act_clr ? 1'b0 : vs_q;
		c_ws    = ptok_pkg::is_ws(cval);
		hold    = act_ch && c_ws && (ckind == ptok_pkg::KIND_KEY || vs_e);
		hold_wr = hold && (cnt_e < CW'(PEND_DEPTH));
		emit    = act_ch && !c_ws;
		cnt_n   = cnt_e;
		rd_n    = rd_e;
		ovf_n   = ovf_e;
		vs_n    = vs_e;
		if (hold_wr)
			cnt_n = cnt_e + CW'(1);
		else if (hold)
			rd_n = 1'b1;
		if (emit) begin
			cnt_n = '0;
			ovf_n = ovf_e | rd_e;
			rd_n  = 1'b0;
			if (ckind == ptok_pkg::KIND_VALUE)
				vs_n = 1'b1;
		end
		if (act_sv) begin
			cnt_n = '0;
			rd_n  = 1'b0;
			vs_n  = 1'b0;
		end
		if (act_end) begin
			cnt_n = '0;
			rd_n  = 1'b0;
			ovf_n = 1'b0;
			vs_n  = 1'b0;
		end
	end

	assign stat.has_flush  = emit && (cnt_e != '0);
	assign stat.has_char   = emit;
	assign stat.has_end    = act_end;
	assign stat.slot_free  = !ov_q || out_ready;
	assign stat.flush_last = (CW'(idx_q + CW'(1)) == fl_n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ptok_pkg::MODE_LINE;
			vs_q    <= 1'b0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			rdrop_q <= 1'b0;
		end else if (cmd.accept) begin
			mode_q  <= nmode;
			vs_q    <= vs_n;
			cnt_q   <= cnt_n;
			ovf_q   <= ovf_n;
			rdrop_q <= rd_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && hold_wr)
			mem_q[cnt_e[AW-1:0]] <= cval;
		if (cmd.rd)
			rd_data_q <= mem_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fl_n_q     <= cnt_e;
			chr_q      <= cval;
			chr_kind_q <= ckind;
			end_ovf_q  <= ovf_q;
			idx_q      <= '0;
		end else if (cmd.ld_flush) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.ld_flush || cmd.ld_char || cmd.ld_end)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_flush) begin
			kind_q <= chr_kind_q;
			ch_q   <= rd_data_q;
			ovfo_q <= 1'b0;
			last_q <= 1'b0;
		end else if (cmd.ld_char) begin
			kind_q <= chr_kind_q;
			ch_q   <= chr_q;
			ovfo_q <= 1'b0;
			last_q <= 1'b1;
		end else if (cmd.ld_end) begin
			kind_q <= ptok_pkg::KIND_END;
			ch_q   <= ptok_pkg::CH_NUL;
			ovfo_q <= end_ovf_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid = ov_q;
	assign kind      = kind_q;
	assign ch        = ch_q;
	assign overflow  = ovfo_q;
	assign last      = last_q;

endmodule

### hw/rtl/ptok_checker.sv
// Port-level checks of the property line tokenizer, bound to the top level.
module ptok_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] ch,
	input logic       overflow,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(ch)
			&& $stable(overflow) && $stable(last))
		else $error("output changed while stalled");

	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ptok_pkg::KIND_END |-> last && ch == ptok_pkg::CH_NUL)
		else $error("pair end not final or carries a byte");

	a_ovf_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != ptok_pkg::KIND_END |-> !overflow)
		else $error("overflow on a byte result");

	a_flush_ws: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> kind != ptok_pkg::KIND_END
			&& (ch == ptok_pkg::CH_SP || (ch >= ptok_pkg::CH_TAB && ch <= ptok_pkg::CH_CR)))
		else $error("non-final result is not held whitespace");

endmodule

bind property_line_tokenizer ptok_checker u_ptok_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.ch        (ch),
	.overflow  (overflow),
	.last      (last)
);
